>>> design/owm_pkg.sv
// shared types and codes for the one-wire bus master timing block
// no dependencies

package owm_pkg;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_RST_LOW   = 3'd1,
      PH_PRES      = 3'd2,
      PH_SLOT_LOW  = 3'd3,
      PH_SLOT_WAIT = 3'd4,
      PH_SAMPLE    = 3'd5,
      PH_RECOVER   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      OP_RESET     = 2'd0,
      OP_WRITE     = 2'd1,
      OP_READ_BYTE = 2'd2,
      OP_READ_BIT  = 2'd3
   } op_type;

   localparam logic [2:0] REQ_TICK      = 3'd0;
   localparam logic [2:0] REQ_RESET     = 3'd1;
   localparam logic [2:0] REQ_WRITE     = 3'd2;
   localparam logic [2:0] REQ_READ_BYTE = 3'd3;
   localparam logic [2:0] REQ_READ_BIT  = 3'd4;

   localparam logic [2:0] CSR_RESET_LOW      = 3'd0;
   localparam logic [2:0] CSR_PRESENCE_WIN   = 3'd1;
   localparam logic [2:0] CSR_SHORT_LOW      = 3'd2;
   localparam logic [2:0] CSR_ZERO_LOW       = 3'd3;
   localparam logic [2:0] CSR_ONE_RECOVERY   = 3'd4;
   localparam logic [2:0] CSR_READ_SAMPLE    = 3'd5;
   localparam logic [2:0] CSR_READ_RECOVERY  = 3'd6;

   localparam int CSR_WIDTH = 16;

endpackage

>>> design/one_wire_master_timing.sv
// one-wire bus master slot timing, stepped by tick beats
// depends on owm_pkg
//
// channel   dir  handshake            payload
// req       in   req_tvalid/tready    tuser: req_type; tdata: data_byte, line_level
// rsp       out  rsp_tvalid/tready    tdata: drive_low, busy, done, presence, read_data
// csr       in   csr_valid/ready      csr_index, csr_data
//
// one beat per cycle while the rsp register can take it: each req beat updates the slot state
// and loads the rsp register in the same cycle; the result appears in the cycle after acceptance
// req is taken whenever the rsp register is empty or being drained
// csr writes are always taken
// synchronous reset restores the register defaults, an idle slot state and an empty rsp register

module one_wire_master_timing #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [8] line_level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] drive_low, [1] busy, [2] done, [3] presence,
                                    // [11:4] read_data
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [owm_pkg::CSR_WIDTH-1:0] csr_data
);

   localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

   typedef logic [COUNT_BITS-1:0] cnt_type;

   logic [15:0] reset_low_ff, presence_win_ff, short_low_ff, zero_low_ff;
   logic [15:0] one_recovery_ff, read_sample_ff, read_recovery_ff;

   owm_pkg::phase_type phase_ff, phase_in;
   owm_pkg::op_type    op_ff, op_in;
   cnt_type            count_ff, count_in;
   logic [2:0]         bit_ff, bit_in;
   logic [7:0]         shift_ff, shift_in;
   logic               pres_ff, pres_in;

   logic        rsp_valid_ff;
   logic        drive_ff, busy_ff, done_ff, presence_ff;
   logic [7:0]  rdata_ff;
   logic        drive_in, busy_in, done_in;
   logic [7:0]  rdata_in;

   logic        accept;
   logic [2:0]  req_type;
   logic [7:0]  data_byte;
   logic        line_level;

   function automatic cnt_type fit(input logic [15:0] v, input logic min_one);
      logic [32:0] w;
      w = {17'd0, v};
      if (min_one && v == 16'd0)
         w = 33'd1;
      if (w > CNT_MAX)
         w = CNT_MAX;
      return w[COUNT_BITS-1:0];
   endfunction

   assign req_type   = req_tuser;
   assign data_byte  = req_tdata[7:0];
   assign line_level = req_tdata[8];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // next state
   always_comb begin
      owm_pkg::phase_type ph;
      owm_pkg::op_type    op;
      cnt_type            cnt;
      logic [2:0]         bi;
      logic [7:0]         sh;
      logic               pr;
      logic               bit_end;
      logic               done;

      ph = phase_ff;
      op = op_ff;
      cnt = count_ff;
      bi = bit_ff;
      sh = shift_ff;
      pr = pres_ff;
      bit_end = 1'b0;
      done = 1'b0;

      // command start
      if (phase_ff == owm_pkg::PH_IDLE && req_type >= owm_pkg::REQ_RESET &&
          req_type <= owm_pkg::REQ_READ_BIT) begin
         bi = 3'd0;
         case (req_type)
            owm_pkg::REQ_RESET: begin
               op = owm_pkg::OP_RESET;
               sh = 8'd0;
               pr = 1'b0;
               ph = owm_pkg::PH_RST_LOW;
               cnt = fit(reset_low_ff, 1'b1);
            end
            owm_pkg::REQ_WRITE: begin
               op = owm_pkg::OP_WRITE;
               sh = data_byte;
               ph = owm_pkg::PH_SLOT_LOW;
               cnt = data_byte[0] ? fit(short_low_ff, 1'b1) : fit(zero_low_ff, 1'b1);
            end
            owm_pkg::REQ_READ_BYTE: begin
               op = owm_pkg::OP_READ_BYTE;
               sh = 8'd0;
               ph = owm_pkg::PH_SLOT_LOW;
               cnt = fit(short_low_ff, 1'b1);
            end
            default: begin
               op = owm_pkg::OP_READ_BIT;
               sh = 8'd0;
               ph = owm_pkg::PH_SLOT_LOW;
               cnt = fit(short_low_ff, 1'b1);
            end
         endcase
      end

      drive_in = (ph == owm_pkg::PH_RST_LOW) || (ph == owm_pkg::PH_SLOT_LOW);

      if (ph != owm_pkg::PH_IDLE) begin
         if (ph == owm_pkg::PH_PRES && !line_level)
            pr = 1'b1;
         if (ph == owm_pkg::PH_SAMPLE) begin
            if (op == owm_pkg::OP_READ_BIT)
               sh = {7'd0, line_level};
            else
               sh = {line_level, sh[7:1]};
         end
         if (cnt != '0)
            cnt = cnt - COUNT_BITS'(1);
         if (cnt == '0) begin
            // phase expired, skip empty phases
            case (ph)
               owm_pkg::PH_RST_LOW: begin
                  ph = owm_pkg::PH_PRES;
                  cnt = fit(presence_win_ff, 1'b1);
               end
               owm_pkg::PH_SLOT_LOW: begin
                  if (op == owm_pkg::OP_WRITE) begin
                     if (!sh[0]) begin
                        bit_end = 1'b1;
                     end else begin
                        ph = owm_pkg::PH_SLOT_WAIT;
                        cnt = fit(one_recovery_ff, 1'b0);
                        if (cnt == '0)
                           bit_end = 1'b1;
                     end
                  end else begin
                     ph = owm_pkg::PH_SLOT_WAIT;
                     cnt = fit(read_sample_ff, 1'b0);
                     if (cnt == '0) begin
                        ph = owm_pkg::PH_SAMPLE;
                        cnt = COUNT_BITS'(1);
                     end
                  end
               end
               owm_pkg::PH_SLOT_WAIT: begin
                  if (op == owm_pkg::OP_WRITE) begin
                     bit_end = 1'b1;
                  end else begin
                     ph = owm_pkg::PH_SAMPLE;
                     cnt = COUNT_BITS'(1);
                  end
               end
               owm_pkg::PH_SAMPLE: begin
                  ph = owm_pkg::PH_RECOVER;
                  cnt = fit(read_recovery_ff, 1'b0);
                  if (cnt == '0)
                     bit_end = 1'b1;
               end
               owm_pkg::PH_RECOVER: begin
                  bit_end = 1'b1;
               end
               default: begin
                  ph = owm_pkg::PH_IDLE;
                  cnt = '0;
                  done = 1'b1;
               end
            endcase
            if (bit_end) begin
               if (op == owm_pkg::OP_WRITE)
                  sh = {1'b0, sh[7:1]};
               if (op == owm_pkg::OP_READ_BIT || bi == 3'd7) begin
                  ph = owm_pkg::PH_IDLE;
                  cnt = '0;
                  done = 1'b1;
               end else begin
                  bi = bi + 3'd1;
                  ph = owm_pkg::PH_SLOT_LOW;
                  cnt = (op == owm_pkg::OP_WRITE && !sh[0]) ?
                        fit(zero_low_ff, 1'b1) : fit(short_low_ff, 1'b1);
               end
            end
         end
      end

      phase_in = ph;
      op_in    = op;
      count_in = cnt;
      bit_in   = bi;
      shift_in = sh;
      pres_in  = pr;
      done_in  = done;
   end

   // result fields
   always_comb begin
      busy_in  = (phase_in != owm_pkg::PH_IDLE);
      rdata_in = (done_in && (op_in == owm_pkg::OP_READ_BYTE ||
                              op_in == owm_pkg::OP_READ_BIT)) ? shift_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= 16'd2500;
         presence_win_ff  <= 16'd255;
         short_low_ff     <= 16'd2;
         zero_low_ff      <= 16'd275;
         one_recovery_ff  <= 16'd260;
         read_sample_ff   <= 16'd1;
         read_recovery_ff <= 16'd140;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            owm_pkg::CSR_RESET_LOW:     reset_low_ff     <= csr_data;
            owm_pkg::CSR_PRESENCE_WIN:  presence_win_ff  <= csr_data;
            owm_pkg::CSR_SHORT_LOW:     short_low_ff     <= csr_data;
            owm_pkg::CSR_ZERO_LOW:      zero_low_ff      <= csr_data;
            owm_pkg::CSR_ONE_RECOVERY:  one_recovery_ff  <= csr_data;
            owm_pkg::CSR_READ_SAMPLE:   read_sample_ff   <= csr_data;
            owm_pkg::CSR_READ_RECOVERY: read_recovery_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owm_pkg::PH_IDLE;
         op_ff    <= owm_pkg::OP_RESET;
         count_ff <= '0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         pres_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         count_ff <= count_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pres_ff  <= pres_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (accept)
         rsp_valid_ff <= 1'b1;
      else if (rsp_tready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         drive_ff    <= drive_in;
         busy_ff     <= busy_in;
         done_ff     <= done_in;
         presence_ff <= pres_in;
         rdata_ff    <= rdata_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rdata_ff, presence_ff, done_ff, busy_ff, drive_ff};

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff)
      else $error("done beat still busy");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !busy_ff && !done_ff |-> !drive_ff && rdata_ff == 8'd0)
      else $error("idle beat drives bus or carries data");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      phase_ff != owm_pkg::PH_IDLE |-> count_ff != '0)
      else $error("active phase with empty counter");

   a_rdata_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rdata_ff != 8'd0 |-> done_ff)
      else $error("read data outside done beat");

endmodule

>>> tb/sv/tb_one_wire_master_timing.sv
// testbench for one_wire_master_timing: tick beats drive reset, write, read slots
// a scoreboard class predicts every rsp beat and compares it field by field
// depends on owm_pkg and the one_wire_master_timing rtl
`timescale 1ns / 1ps

module tb_one_wire_master_timing;

   localparam int unsigned COUNT_MAX = (1 << 16) - 1;
   localparam logic [2:0] REQ_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] REQ_LAST_CODE = 3'd7;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int IDLE_NONE = 0;
   localparam int IDLE_SEND = 1;
   localparam int IDLE_RECV = 2;
   localparam int IDLE_BOTH = 3;

   typedef struct packed {
      logic [3:0] pad;
      logic [7:0] read_data;
      logic       presence;
      logic       done;
      logic       busy;
      logic       drive_low;
   } line_result_type;

   class bus_slot_scoreboard;
      logic [15:0]         timing [0:6];
      owm_pkg::phase_type  ph;
      owm_pkg::op_type     op;
      int unsigned         slot_ticks;
      logic [2:0]          bit_pos;
      logic [7:0]          shift_reg;
      logic                presence_seen;
      line_result_type     pending_line_states [$];
      int                  errors;

      function new();
         timing[owm_pkg::CSR_RESET_LOW] = 16'd2500;
         timing[owm_pkg::CSR_PRESENCE_WIN] = 16'd255;
         timing[owm_pkg::CSR_SHORT_LOW] = 16'd2;
         timing[owm_pkg::CSR_ZERO_LOW] = 16'd275;
         timing[owm_pkg::CSR_ONE_RECOVERY] = 16'd260;
         timing[owm_pkg::CSR_READ_SAMPLE] = 16'd1;
         timing[owm_pkg::CSR_READ_RECOVERY] = 16'd140;
         ph = owm_pkg::PH_IDLE;
         op = owm_pkg::OP_RESET;
         slot_ticks = 0;
         bit_pos = '0;
         shift_reg = '0;
         presence_seen = 1'b0;
         errors = 0;
      endfunction

      function void set_timing(logic [2:0] idx, logic [15:0] value);
         if (idx <= owm_pkg::CSR_READ_RECOVERY) timing[idx] = value;
      endfunction

      function bit busy();
         return ph != owm_pkg::PH_IDLE;
      endfunction

      function int pending();
         return pending_line_states.size();
      endfunction

      function void load_phase(owm_pkg::phase_type p, int unsigned len,
                               int unsigned min_len);
         ph = p;
         if (len < min_len) len = min_len;
         if (len > COUNT_MAX) len = COUNT_MAX;
         slot_ticks = len;
      endfunction

      function void start_slot();
         if (op == owm_pkg::OP_WRITE && !shift_reg[0])
            load_phase(owm_pkg::PH_SLOT_LOW, timing[owm_pkg::CSR_ZERO_LOW], 1);
         else
            load_phase(owm_pkg::PH_SLOT_LOW, timing[owm_pkg::CSR_SHORT_LOW], 1);
      endfunction

      // walk past expired and empty phases, returns 1 when the command completes
      function bit advance_slot();
         bit fin;
         bit stop;
         bit bit_end;
         fin = 1'b0;
         stop = 1'b0;
         while (!stop) begin
            bit_end = 1'b0;
            case (ph)
               owm_pkg::PH_RST_LOW:
                  load_phase(owm_pkg::PH_PRES, timing[owm_pkg::CSR_PRESENCE_WIN], 1);
               owm_pkg::PH_SLOT_LOW: begin
                  if (op == owm_pkg::OP_WRITE) begin
                     if (!shift_reg[0]) bit_end = 1'b1;
                     else load_phase(owm_pkg::PH_SLOT_WAIT,
                                     timing[owm_pkg::CSR_ONE_RECOVERY], 0);
                  end else begin
                     load_phase(owm_pkg::PH_SLOT_WAIT, timing[owm_pkg::CSR_READ_SAMPLE], 0);
                  end
               end
               owm_pkg::PH_SLOT_WAIT: begin
                  if (op == owm_pkg::OP_WRITE) bit_end = 1'b1;
                  else load_phase(owm_pkg::PH_SAMPLE, 1, 1);
               end
               owm_pkg::PH_SAMPLE:
                  load_phase(owm_pkg::PH_RECOVER, timing[owm_pkg::CSR_READ_RECOVERY], 0);
               owm_pkg::PH_RECOVER: bit_end = 1'b1;
               default: begin
                  ph = owm_pkg::PH_IDLE;
                  slot_ticks = 0;
                  fin = 1'b1;
                  stop = 1'b1;
               end
            endcase
            if (bit_end) begin
               if (op == owm_pkg::OP_WRITE) shift_reg = shift_reg >> 1;
               if (op == owm_pkg::OP_READ_BIT || bit_pos == 3'd7) begin
                  ph = owm_pkg::PH_IDLE;
                  slot_ticks = 0;
                  fin = 1'b1;
                  stop = 1'b1;
               end else begin
                  bit_pos = bit_pos + 3'd1;
                  start_slot();
               end
            end
            if (!stop && slot_ticks != 0) stop = 1'b1;
         end
         return fin;
      endfunction

      function void note_tick_beat(logic [2:0] kind, logic [7:0] data, logic lvl);
         line_result_type want;
         bit fin;
         logic drv;
         logic [7:0] rd;
         fin = 1'b0;
         drv = 1'b0;
         rd = '0;
         if (ph == owm_pkg::PH_IDLE && kind >= owm_pkg::REQ_RESET &&
             kind <= owm_pkg::REQ_READ_BIT) begin
            bit_pos = '0;
            if (kind == owm_pkg::REQ_RESET) begin
               op = owm_pkg::OP_RESET;
               shift_reg = '0;
               presence_seen = 1'b0;
               load_phase(owm_pkg::PH_RST_LOW, timing[owm_pkg::CSR_RESET_LOW], 1);
            end else begin
               case (kind)
                  owm_pkg::REQ_WRITE: op = owm_pkg::OP_WRITE;
                  owm_pkg::REQ_READ_BYTE: op = owm_pkg::OP_READ_BYTE;
                  default: op = owm_pkg::OP_READ_BIT;
               endcase
               shift_reg = (kind == owm_pkg::REQ_WRITE) ? data : 8'd0;
               start_slot();
            end
         end
         if (ph != owm_pkg::PH_IDLE) begin
            drv = (ph == owm_pkg::PH_RST_LOW || ph == owm_pkg::PH_SLOT_LOW);
            if (ph == owm_pkg::PH_PRES && !lvl) presence_seen = 1'b1;
            if (ph == owm_pkg::PH_SAMPLE) begin
               if (op == owm_pkg::OP_READ_BIT) shift_reg = {7'd0, lvl};
               else shift_reg = {lvl, shift_reg[7:1]};
            end
            if (slot_ticks > 0) slot_ticks--;
            if (slot_ticks == 0) fin = advance_slot();
            if (fin && (op == owm_pkg::OP_READ_BYTE || op == owm_pkg::OP_READ_BIT))
               rd = shift_reg;
         end
         want.pad = '0;
         want.read_data = rd;
         want.presence = presence_seen;
         want.done = fin;
         want.busy = (ph != owm_pkg::PH_IDLE);
         want.drive_low = drv;
         pending_line_states.push_back(want);
      endfunction

      function void check_line_beat(logic [15:0] raw);
         line_result_type got;
         line_result_type want;
         got = raw;
         if (pending_line_states.size() == 0) begin
            errors++;
            if (errors <= 10) $display("%0t: rsp beat %h with nothing expected", $time, raw);
            return;
         end
         want = pending_line_states.pop_front();
         if (got.drive_low !== want.drive_low || got.busy !== want.busy ||
             got.done !== want.done || got.presence !== want.presence ||
             got.read_data !== want.read_data || got.pad !== want.pad) begin
            errors++;
            if (errors <= 10)
               $display({"%0t: rsp mismatch, expected drive_low %b busy %b done %b ",
                         "presence %b read_data %h pad %h, got %b %b %b %b %h %h"},
                        $time, want.drive_low, want.busy, want.done, want.presence,
                        want.read_data, want.pad, got.drive_low, got.busy, got.done,
                        got.presence, got.read_data, got.pad);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;   // [2:0] req_type
   logic [15:0] req_tdata = '0;   // [7:0] data_byte, [8] line_level
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [0] drive_low, [1] busy, [2] done, [3] presence,
                                  // [11:4] read_data
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [owm_pkg::CSR_WIDTH-1:0] csr_data = '0;

   bus_slot_scoreboard sb;
   int idle_mode = IDLE_NONE;
   logic [15:0] timing_plan [0:6];

   one_wire_master_timing uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic bit sender_pauses();
      if (idle_mode == IDLE_SEND) return $urandom_range(99) < 84;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 11;
      return 1'b0;
   endfunction

   function automatic bit receiver_stalls();
      if (idle_mode == IDLE_RECV) return $urandom_range(99) < 84;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 11;
      return 1'b0;
   endfunction

   function automatic logic line_sample(int low_pct);
      return !($urandom_range(99) < low_pct);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_line_beat(rsp_tdata);
      rsp_tready <= !receiver_stalls();
   end

   task automatic send_line_beat(input logic [2:0] kind, input logic [7:0] data,
                                 input logic lvl);
      while (sender_pauses()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, lvl, data};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick_beat(kind, data, lvl);
   endtask

   // ticks until the slot sequence is back to idle, optionally with stray commands
   task automatic settle_bus(input int low_pct, input bit noisy);
      logic [2:0] kind;
      while (sb.busy()) begin
         kind = noisy ? 3'($urandom_range(REQ_LAST_CODE)) : owm_pkg::REQ_TICK;
         send_line_beat(kind, 8'($urandom), line_sample(low_pct));
      end
   endtask

   task automatic run_command(input logic [2:0] kind, input logic [7:0] data,
                              input int low_pct, input bit noisy);
      send_line_beat(kind, data, line_sample(low_pct));
      settle_bus(low_pct, noisy);
   endtask

   task automatic load_timing(input bit poke_unused);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      for (int i = 0; i <= owm_pkg::CSR_READ_RECOVERY; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_data <= timing_plan[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_timing(3'(i), timing_plan[i]);
      end
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_data <= 16'hFFFF;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_timing(CSR_UNUSED, 16'hFFFF);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int beats);
      logic [2:0] kind;
      int r;
      int low_pct;
      low_pct = $urandom_range(10, 90);
      for (int i = 0; i <= owm_pkg::CSR_READ_RECOVERY; i++) begin
         r = $urandom_range(99);
         if (r < 20) timing_plan[i] = 16'd0;
         else if (r < 85) timing_plan[i] = 16'($urandom_range(1, 4));
         else timing_plan[i] = 16'($urandom_range(5, 12));
      end
      load_timing(1'b0);
      repeat (beats) begin
         r = $urandom_range(99);
         if (!sb.busy()) begin
            if (r < 75) kind = 3'($urandom_range(owm_pkg::REQ_RESET, owm_pkg::REQ_READ_BIT));
            else if (r < 88) kind = owm_pkg::REQ_TICK;
            else kind = 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE));
         end else begin
            kind = (r < 85) ? owm_pkg::REQ_TICK : 3'($urandom_range(REQ_LAST_CODE));
         end
         send_line_beat(kind, 8'($urandom), line_sample(low_pct));
      end
      settle_bus(low_pct, 1'b0);
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults
      run_command(owm_pkg::REQ_READ_BIT, 8'h00, 50, 1'b0);

      // all lengths zero, low phases act as one tick
      foreach (timing_plan[i]) timing_plan[i] = '0;
      load_timing(1'b1);
      send_line_beat(owm_pkg::REQ_TICK, 8'hFF, 1'b0);
      for (int k = REQ_FIRST_UNUSED; k <= REQ_LAST_CODE; k++)
         send_line_beat(3'(k), 8'($urandom), 1'b0);
      run_command(owm_pkg::REQ_RESET, 8'h00, 0, 1'b0);
      run_command(owm_pkg::REQ_RESET, 8'hFF, 100, 1'b0);
      run_command(owm_pkg::REQ_WRITE, 8'h00, 50, 1'b0);
      run_command(owm_pkg::REQ_WRITE, 8'hFF, 50, 1'b0);
      run_command(owm_pkg::REQ_WRITE, 8'hA5, 50, 1'b0);
      run_command(owm_pkg::REQ_READ_BYTE, 8'h00, 50, 1'b0);
      run_command(owm_pkg::REQ_READ_BIT, 8'h00, 0, 1'b0);
      run_command(owm_pkg::REQ_READ_BIT, 8'h00, 100, 1'b0);
      run_command(owm_pkg::REQ_READ_BYTE, 8'h3C, 50, 1'b1);

      // mixed short lengths, skipped sample delay and one-bit recovery
      timing_plan[owm_pkg::CSR_RESET_LOW] = 16'd3;
      timing_plan[owm_pkg::CSR_PRESENCE_WIN] = 16'd2;
      timing_plan[owm_pkg::CSR_SHORT_LOW] = 16'd2;
      timing_plan[owm_pkg::CSR_ZERO_LOW] = 16'd4;
      timing_plan[owm_pkg::CSR_ONE_RECOVERY] = 16'd0;
      timing_plan[owm_pkg::CSR_READ_SAMPLE] = 16'd0;
      timing_plan[owm_pkg::CSR_READ_RECOVERY] = 16'd2;
      load_timing(1'b0);
      idle_mode = IDLE_BOTH;
      run_command(owm_pkg::REQ_RESET, 8'h00, 50, 1'b1);
      run_command(owm_pkg::REQ_WRITE, 8'h5A, 50, 1'b1);
      run_command(owm_pkg::REQ_READ_BYTE, 8'h00, 50, 1'b0);
      run_command(owm_pkg::REQ_READ_BIT, 8'h00, 50, 1'b0);

      for (int p = 0; p < 6; p++) begin
         idle_mode = p % 4;
         random_phase(140);
      end

      // longer lengths
      foreach (timing_plan[i]) timing_plan[i] = 16'd20;
      load_timing(1'b0);
      idle_mode = IDLE_NONE;
      run_command(owm_pkg::REQ_RESET, 8'h00, 50, 1'b0);
      run_command(owm_pkg::REQ_READ_BIT, 8'h00, 50, 1'b0);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

>>> filelist.f
design/owm_pkg.sv
design/one_wire_master_timing.sv
tb/sv/tb_one_wire_master_timing.sv
